[src/approximate_text_match_top_macros.svh]
// Assertion macros shared by the approximate text matcher modules
`ifndef APPROXIMATE_TEXT_MATCH_TOP_MACROS_SVH
`define APPROXIMATE_TEXT_MATCH_TOP_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ATM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that one condition implies another in the following cycle
`define ATM_ASSERT_NEXT(label, cond, expect_next, msg) \
    `ATM_ASSERT(label, (cond) |=> (expect_next), msg)

`endif

[src/atm_pkg.sv]
// Shared types, constants and functions of the approximate text matcher
package atm_pkg;

    localparam int PATTERN_MAX  = 31;
    localparam int ERROR_MAX    = 3;
    localparam int ROW_COUNT    = 4;
    localparam int QUEUE_DEPTH  = 4;
    localparam int LEN_W        = $clog2(PATTERN_MAX + 1);
    localparam int K_MAX        = (ERROR_MAX < 3) ? ERROR_MAX : 3;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_INDEX_W  = 3;
    localparam int PAT_REGS     = 4;
    localparam int PAT_BYTES    = PAT_REGS * CFG_DATA_W / 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_A = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_B = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_C = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_D = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ERR_LIMIT = 3'd5;

    typedef logic [PATTERN_MAX-1:0] row_t;

    // One classified text item as it travels through the queue
    typedef struct packed {
        row_t mvec;
        logic valid;
        logic last;
    } item_t;

    // Settings the back part needs for the hit test
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [1:0]       k;
    } match_cfg_t;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        fold_case = ((c >= 8'h41) && (c <= 8'h5a)) ? (c + 8'h20) : c;
    endfunction

    // Row j after reset: all ones except the low j bits
    function automatic row_t init_row(input int j);
        init_row = row_t'({PATTERN_MAX{1'b1}} << j);
    endfunction

endpackage

[src/atm_front.sv]
// Front part: configuration registers and per-byte match vector classification
module atm_front
    import atm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             text_byte,
    input  logic                   byte_valid,
    input  logic                   record_end,
    input  logic                   q_full,
    output logic                   q_push,
    output item_t                  q_item,
    output match_cfg_t             mcfg
);

    logic [PAT_REGS-1:0][CFG_DATA_W-1:0] pattern_reg;
    logic [4:0]                          length_reg;
    logic [1:0]                          err_limit_reg;
    logic [PAT_BYTES*8-1:0]              pat_flat;
    logic [7:0]                          folded;
    row_t                                mvec;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg   <= '0;
            length_reg    <= 5'd1;
            err_limit_reg <= 2'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PATTERN_A: pattern_reg[0] <= cfg_data;
                CFG_PATTERN_B: pattern_reg[1] <= cfg_data;
                CFG_PATTERN_C: pattern_reg[2] <= cfg_data;
                CFG_PATTERN_D: pattern_reg[3] <= cfg_data;
                CFG_LENGTH:    length_reg     <= cfg_data[4:0];
                CFG_ERR_LIMIT: err_limit_reg  <= cfg_data[1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign pat_flat = pattern_reg;

    // Saturate length and error limit to what the rows support
    always_comb
    begin
        mcfg.len = (int'(length_reg) > PATTERN_MAX) ? LEN_W'(PATTERN_MAX)
                                                    : LEN_W'(length_reg);
        mcfg.k   = (int'(err_limit_reg) > K_MAX) ? 2'(K_MAX) : err_limit_reg;
    end

    assign folded = fold_case(text_byte);

    // Clear bit i < len where pattern byte i equals the text byte, ignoring case
    for (genvar i = 0; i < PATTERN_MAX; i++)
    begin : g_cmp
        logic [7:0] pbyte;
        if (i < PAT_BYTES)
        begin : g_reg
            assign pbyte = pat_flat[i*8 +: 8];
        end
        else
        begin : g_zero
            assign pbyte = 8'h00;
        end
        assign mvec[i] = !((LEN_W'(i) < mcfg.len) && (fold_case(pbyte) == folded));
    end

    assign in_ready     = !q_full;
    // Drop items that carry neither a byte nor a record end
    assign q_push       = in_valid && in_ready && (byte_valid || record_end);
    assign q_item.mvec  = mvec;
    assign q_item.valid = byte_valid;
    assign q_item.last  = record_end;

endmodule

[src/atm_queue.sv]
// Short FIFO between the front and back parts
module atm_queue
    import atm_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t push_item,
    input  logic  pop,
    output item_t head,
    output logic  empty,
    output logic  full
);

`include "approximate_text_match_top_macros.svh"

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    `ATM_ASSERT(a_no_push_full, !(push && full), "push into a full queue")
    `ATM_ASSERT(a_no_pop_empty, !(pop && empty), "pop from an empty queue")
    `ATM_ASSERT_NEXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count did not advance")

endmodule

[src/atm_back.sv]
// Back part: bitap row update, sticky hit flag and result register
module atm_back
    import atm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  match_cfg_t mcfg,
    input  logic       q_empty,
    input  item_t      q_head,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       matched
);

`include "approximate_text_match_top_macros.svh"

    row_t rows_reg  [ROW_COUNT];
    row_t rows_next [ROW_COUNT];
    row_t upd       [ROW_COUNT];
    logic found_reg, found_next;
    logic out_valid_reg, out_valid_next;
    logic matched_reg, matched_next;
    row_t acc;
    logic hit;

    // Hold a record end while the result register is still occupied
    assign q_pop = !q_empty && (!q_head.last || !out_valid_reg || out_ready);

    always_comb
    begin
        upd[0] = (rows_reg[0] << 1) | q_head.mvec;
        for (int j = 1; j < ROW_COUNT; j++)
        begin
            upd[j] = ((rows_reg[j] << 1) | q_head.mvec)
                   & ((rows_reg[j-1] & upd[j-1]) << 1)
                   & rows_reg[j-1];
        end
    end

    always_comb
    begin
        acc = upd[0];
        for (int j = 1; j < ROW_COUNT; j++)
        begin
            if (int'(mcfg.k) >= j)
            begin
                acc = acc & upd[j];
            end
        end
        hit = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if ((mcfg.len == LEN_W'(i + 1)) && !acc[i])
            begin
                hit = 1'b1;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < ROW_COUNT; j++)
        begin
            rows_next[j] = rows_reg[j];
        end
        found_next     = found_reg;
        out_valid_next = out_valid_reg && !out_ready;
        matched_next   = matched_reg;
        if (q_pop)
        begin
            if (q_head.valid)
            begin
                for (int j = 0; j < ROW_COUNT; j++)
                begin
                    rows_next[j] = upd[j];
                end
                found_next = found_reg || hit;
            end
            if (q_head.last)
            begin
                out_valid_next = 1'b1;
                matched_next   = q_head.valid ? (found_reg || hit) : found_reg;
                for (int j = 0; j < ROW_COUNT; j++)
                begin
                    rows_next[j] = init_row(j);
                end
                found_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ROW_COUNT; j++)
            begin
                rows_reg[j] <= init_row(j);
            end
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int j = 0; j < ROW_COUNT; j++)
            begin
                rows_reg[j] <= rows_next[j];
            end
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

    `ATM_ASSERT_NEXT(a_rows_reinit, q_pop && q_head.last, (rows_reg[0] == init_row(0)) && !found_reg, "rows not reinitialized after record end")
    `ATM_ASSERT_NEXT(a_result_loaded, q_pop && q_head.last, out_valid_reg, "record end gave no result")
    `ATM_ASSERT(a_no_overwrite, !(q_pop && q_head.last && out_valid_reg && !out_ready), "result overwritten while stalled")

endmodule

[src/approximate_text_match_top.sv]
// Top level of the approximate text matcher: front, queue and back parts
// Usage:
//   Text bytes enter on the in_valid / in_ready channel, one transfer per byte,
//   with record_end on the last byte of a record. An empty record is one
//   transfer with byte_valid low and record_end high.
//   Each record gives one result transfer on out_valid / out_ready: matched is
//   high if the pattern occurs in the record within error_limit edits
//   (substitution, insertion or deletion), letters compared without case.
//   A record's last byte is written into the queue when it is taken; the row
//   update and result load follow when the back part pops it from the queue.
//   Throughput: one byte per cycle while in_ready is high; the four bitap rows
//   update together in the back part, and the front compares the byte against
//   all pattern bytes in parallel.
//   When the receiver stalls, the result register holds the result and the
//   back part keeps consuming bytes of the next record; only the next record
//   end waits. The queue then fills and in_ready drops.
//   Reset clears the queue, the rows, the hit flag and the configuration
//   (pattern zero, length one, error limit zero). Write configuration through
//   cfg_we / cfg_index / cfg_data only while no record is in flight.
module approximate_text_match_top
    import atm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [7:0]             text_byte,
    input  logic                   byte_valid,
    input  logic                   record_end,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   matched
);

    item_t      push_item;
    item_t      head;
    match_cfg_t mcfg;
    logic       push, pop, q_empty, q_full;

    atm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .text_byte  (text_byte),
        .byte_valid (byte_valid),
        .record_end (record_end),
        .q_full     (q_full),
        .q_push     (push),
        .q_item     (push_item),
        .mcfg       (mcfg)
    );

    atm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    atm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .mcfg      (mcfg),
        .q_empty   (q_empty),
        .q_head    (head),
        .q_pop     (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .matched   (matched)
    );

endmodule
